// ===== design/lbs_pkg.sv =====
package lbs_pkg;

  localparam int MAX_HANDLES = 16;
  localparam int COORD_BITS  = 32;
  localparam int OUT_BITS    = (COORD_BITS > 32) ? 32 : COORD_BITS;

  localparam int COEFFS    = 12;
  localparam int TBL_DEPTH = MAX_HANDLES * COEFFS;
  localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int IDX_W     = $clog2(COEFFS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COEFFS - 1);

  localparam int FRAC_BITS = 16;
  localparam int RND_W     = 49;  // 64-bit product shifted down by 16, plus sign
  localparam int TERM_W    = 51;  // four rounded terms summed
  localparam int TC_W      = 47;  // term after clamp to +-(2^46-1)

  localparam logic signed [TERM_W-1:0] TERM_LIM = (TERM_W'(1) <<< 46) - TERM_W'(1);
  localparam logic signed [RND_W-1:0]  OUT_HI   =
    (RND_W'(1) <<< (OUT_BITS - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0]  OUT_LO   = -(RND_W'(1) <<< (OUT_BITS - 1));
  localparam logic signed [63:0] SUM_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] SUM_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;

  localparam logic MODE_LOAD   = 1'b0;
  localparam logic MODE_VERTEX = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_EMIT
  } lbs_state_t;

  // coefficient read issued to the table this cycle
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } lbs_rd_t;

  typedef struct packed {
    logic        busy;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        sat;
  } lbs_sts_t;

  // round half up to Q16.16 and clamp to the output range; {hit, value}
  function automatic logic [32:0] emit_round(logic signed [63:0] s);
    logic signed [64:0]      t;
    logic signed [RND_W-1:0] q;
    logic [32:0]             r;
    t = {s[63], s} + 65'sd32768;
    q = t[64:FRAC_BITS];
    if (q > OUT_HI) begin
      r = {1'b1, OUT_HI[31:0]};
    end else if (q < OUT_LO) begin
      r = {1'b1, OUT_LO[31:0]};
    end else begin
      r = {1'b0, q[31:0]};
    end
    return r;
  endfunction

endpackage

// ===== design/lbs_tbl.sv =====
module lbs_tbl (
  input  logic                      clk,
  input  logic                      we,
  input  logic [lbs_pkg::TBL_AW-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic [lbs_pkg::TBL_AW-1:0] raddr,
  output logic [31:0]               rdata
);
  import lbs_pkg::*;

  logic [31:0] mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lbs_mac.sv =====
module lbs_mac (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lbs_pkg::lbs_rd_t        rd_ctl,
  input  logic [31:0]             rd_data,
  input  logic signed [31:0]      pos_x,
  input  logic signed [31:0]      pos_y,
  input  logic signed [31:0]      pos_z,
  input  logic [16:0]             weight,
  input  logic                    clr,
  output lbs_pkg::lbs_sts_t       sts
);
  import lbs_pkg::*;

  // stage 1: table data lines up with its index
  logic             v1_r;
  logic [IDX_W-1:0] idx1_r;
  // stage 2: coefficient times position
  logic                v2_r;
  logic [IDX_W-1:0]    idx2_r;
  logic signed [31:0]  op;
  logic signed [63:0]  prod_r;
  // stage 3: row term accumulation
  logic signed [64:0]       prod_ext;
  logic signed [RND_W-1:0]  rnd;
  logic signed [TERM_W-1:0] term_nxt;
  logic signed [TERM_W-1:0] term_acc_r;
  logic                     term_vld_r;
  logic [1:0]               term_row_r;
  // stage 4: clamp
  logic signed [TC_W-1:0] tc_r;
  logic                   tc_hit_r;
  logic                   tc_vld_r;
  logic [1:0]             tc_row_r;
  // stage 5: weight
  logic signed [64:0] wp_full;
  logic signed [63:0] wp_r;
  logic               wp_hit_r;
  logic               wp_vld_r;
  logic [1:0]         wp_row_r;
  // stage 6: saturating sums
  logic signed [63:0] sum_x_r, sum_y_r, sum_z_r;
  logic signed [63:0] sum_sel;
  logic signed [64:0] add;
  logic signed [63:0] add_sat;
  logic               add_ovf;
  logic               clamp_seen_r;
  logic [32:0]        ex, ey, ez;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      term_vld_r <= 1'b0;
      tc_vld_r   <= 1'b0;
      wp_vld_r   <= 1'b0;
    end else begin
      v1_r       <= rd_ctl.vld;
      v2_r       <= v1_r;
      term_vld_r <= v2_r && (idx2_r[1:0] == 2'd3);
      tc_vld_r   <= term_vld_r;
      wp_vld_r   <= tc_vld_r;
    end
  end

  // translation column multiplies by 1.0 so every column rounds the same way
  always_comb begin
    case (idx1_r[1:0])
      2'd0:    op = pos_x;
      2'd1:    op = pos_y;
      2'd2:    op = pos_z;
      default: op = ONE_Q16;
    endcase
  end

  assign prod_ext = {prod_r[63], prod_r} + 65'sd32768;
  assign rnd      = prod_ext[64:FRAC_BITS];
  assign term_nxt = ((idx2_r[1:0] == 2'd0) ? '0 : term_acc_r)
                  + {{(TERM_W - RND_W){rnd[RND_W-1]}}, rnd};

  assign wp_full = tc_r * $signed({1'b0, weight});

  always_ff @(posedge clk) begin
    idx1_r <= rd_ctl.idx;
    idx2_r <= idx1_r;
    prod_r <= $signed(rd_data) * op;
    if (v2_r) begin
      term_acc_r <= term_nxt;
    end
    term_row_r <= idx2_r[IDX_W-1:2];
    tc_row_r   <= term_row_r;
    if (term_acc_r > TERM_LIM) begin
      tc_r     <= TERM_LIM[TC_W-1:0];
      tc_hit_r <= 1'b1;
    end else if (term_acc_r < -TERM_LIM) begin
      tc_r     <= -TERM_LIM[TC_W-1:0];
      tc_hit_r <= 1'b1;
    end else begin
      tc_r     <= term_acc_r[TC_W-1:0];
      tc_hit_r <= 1'b0;
    end
    wp_r     <= wp_full[63:0];
    wp_hit_r <= tc_hit_r;
    wp_row_r <= tc_row_r;
  end

  always_comb begin
    case (wp_row_r)
      2'd0:    sum_sel = sum_x_r;
      2'd1:    sum_sel = sum_y_r;
      default: sum_sel = sum_z_r;
    endcase
  end

  assign add     = {sum_sel[63], sum_sel} + {wp_r[63], wp_r};
  assign add_ovf = add[64] ^ add[63];
  assign add_sat = add_ovf ? (add[64] ? SUM_MIN : SUM_MAX) : add[63:0];

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sum_x_r      <= '0;
      sum_y_r      <= '0;
      sum_z_r      <= '0;
      clamp_seen_r <= 1'b0;
    end else if (wp_vld_r) begin
      case (wp_row_r)
        2'd0:    sum_x_r <= add_sat;
        2'd1:    sum_y_r <= add_sat;
        default: sum_z_r <= add_sat;
      endcase
      clamp_seen_r <= clamp_seen_r | wp_hit_r | add_ovf;
    end
  end

  assign ex = emit_round(sum_x_r);
  assign ey = emit_round(sum_y_r);
  assign ez = emit_round(sum_z_r);

  assign sts.busy = v1_r | v2_r | term_vld_r | tc_vld_r | wp_vld_r;
  assign sts.x    = ex[31:0];
  assign sts.y    = ey[31:0];
  assign sts.z    = ez[31:0];
  assign sts.sat  = clamp_seen_r | ex[32] | ey[32] | ez[32];

endmodule

// ===== design/linear_blend_skinning.sv =====
// Load items are accepted one per cycle while idle and may follow back to back.
// A vertex term makes 12 coefficient reads through the table's single read port,
// then a 6-stage multiply/round/weight/accumulate pipeline drains. On a last term
// the result is loaded into the output register once any earlier result is taken.
// A term with an out-of-range handle adds nothing. Reset clears the sums and
// control; the transform table is not cleared and holds garbage until loaded.
module linear_blend_skinning (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic [3:0]         in_handle,
  input  logic [3:0]         in_element,
  input  logic signed [31:0] in_coeff,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [16:0]        in_weight,
  input  logic               in_last_term,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_saturated
);
  import lbs_pkg::*;

  lbs_state_t state_r, state_nxt;

  logic [IDX_W-1:0]  idx_r;
  logic [TBL_AW-1:0] base_r;
  logic [TBL_AW-1:0] hbase;
  logic [TBL_AW-1:0] waddr;
  logic [TBL_AW-1:0] raddr;
  logic [31:0]       rd_data;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [16:0]       weight_r;
  logic              last_r;
  logic              handle_ok;
  logic              elem_ok;
  logic              in_xfer;
  logic              tbl_we;
  logic              emit_go;
  lbs_rd_t           rd_ctl;
  lbs_sts_t          mac_sts;

  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               out_sat_r;

  assign handle_ok = int'(in_handle) < MAX_HANDLES;
  assign elem_ok   = int'(in_element) < COEFFS;
  assign in_xfer   = in_valid && !in_stall;
  assign hbase     = TBL_AW'(in_handle) * TBL_AW'(COEFFS);
  assign waddr     = hbase + TBL_AW'(in_element);
  assign raddr     = base_r + TBL_AW'(idx_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_mode == MODE_VERTEX) begin
          if (handle_ok) begin
            state_nxt = S_RUN;
          end else if (in_last_term) begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_RUN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!mac_sts.busy) begin
          state_nxt = last_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall   = 1'b1;
    tbl_we     = 1'b0;
    rd_ctl.vld = 1'b0;
    rd_ctl.idx = idx_r;
    emit_go    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        tbl_we   = in_valid && in_mode == MODE_LOAD && handle_ok && elem_ok;
      end
      S_RUN:   rd_ctl.vld = 1'b1;
      S_DRAIN: ;
      S_EMIT:  emit_go = !out_valid_r || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_RUN) begin
        idx_r <= idx_r + IDX_W'(1);
      end else begin
        idx_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      base_r   <= hbase;
      pos_x_r  <= in_pos_x;
      pos_y_r  <= in_pos_y;
      pos_z_r  <= in_pos_z;
      weight_r <= in_weight;
      last_r   <= in_last_term;
    end
  end

  // writes happen only while idle, so no read of the same entry is in flight
  lbs_tbl u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (waddr),
    .wdata (in_coeff),
    .raddr (raddr),
    .rdata (rd_data)
  );

  lbs_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_ctl  (rd_ctl),
    .rd_data (rd_data),
    .pos_x   (pos_x_r),
    .pos_y   (pos_y_r),
    .pos_z   (pos_z_r),
    .weight  (weight_r),
    .clr     (emit_go),
    .sts     (mac_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_x_r   <= mac_sts.x;
      out_y_r   <= mac_sts.y;
      out_z_r   <= mac_sts.z;
      out_sat_r <= mac_sts.sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_z         = out_z_r;
  assign out_saturated = out_sat_r;

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    emit_go |-> !mac_sts.busy)
    else $error("result taken while terms still in the pipeline");

  a_no_write_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    tbl_we |-> !mac_sts.busy && !rd_ctl.vld)
    else $error("table write while coefficient reads in flight");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> idx_r <= LAST_IDX)
    else $error("coefficient index past end of row set");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_EMIT)
    else $error("result appeared without an emit");

endmodule

// ===== test/tb_linear_blend_skinning.sv =====
`timescale 1ns / 100ps

module tb_linear_blend_skinning;
  import lbs_pkg::*;

  localparam int N_RANDOM = 1450;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 30;
  localparam logic signed [63:0] TERM_CAP = 64'sd70368744177663;  // 2^46 - 1

  typedef struct {
    logic               mode;
    logic [3:0]         handle;
    logic [3:0]         element;
    logic signed [31:0] coeff;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [16:0]        weight;
    logic               last;
    bit                 sync;  // hold off until every result is back
  } skin_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               sat;
  } vert_out_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_mode;
  logic [3:0]         in_handle;
  logic [3:0]         in_element;
  logic signed [31:0] in_coeff;
  logic signed [31:0] in_pos_x;
  logic signed [31:0] in_pos_y;
  logic signed [31:0] in_pos_z;
  logic [16:0]        in_weight;
  logic               in_last_term;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               out_saturated;

  linear_blend_skinning uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_handle     (in_handle),
    .in_element    (in_element),
    .in_coeff      (in_coeff),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_weight     (in_weight),
    .in_last_term  (in_last_term),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_saturated (out_saturated)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  skin_item_t pending_items[$];
  vert_out_t  expected_verts[$];
  int         mismatches = 0;
  int         accepted_items = 0;
  int         total_items = 0;
  int         hold_left = 0;
  int         holds_done = 0;

  // predictor state
  logic signed [31:0] xform [MAX_HANDLES][COEFFS];
  logic signed [63:0] acc_x = '0;
  logic signed [63:0] acc_y = '0;
  logic signed [63:0] acc_z = '0;
  bit                 clamp_flag = 1'b0;

  // stimulus-side record of loaded coefficients, so no unloaded entry is read
  logic [COEFFS-1:0] gen_loaded [MAX_HANDLES];
  int                gen_count;
  bit                sync_next;

  // v / 2^16, rounded half up
  function automatic logic signed [63:0] rnd_q16(input logic signed [63:0] v);
    logic signed [64:0] t;
    t = {v[63], v};
    t = t + 65'sd32768;
    t = t >>> FRAC_BITS;
    return t[63:0];
  endfunction

  function automatic logic signed [63:0] row_term(input int h, input int r,
                                                  input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z);
    logic signed [63:0] c0, c1, c2, c3, xs, ys, zs, t;
    c0 = xform[h][4*r];
    c1 = xform[h][4*r+1];
    c2 = xform[h][4*r+2];
    c3 = xform[h][4*r+3];
    xs = x;
    ys = y;
    zs = z;
    t = rnd_q16(c0 * xs) + rnd_q16(c1 * ys) + rnd_q16(c2 * zs) + c3;
    if (t > TERM_CAP) begin
      t = TERM_CAP;
      clamp_flag = 1'b1;
    end else if (t < -TERM_CAP) begin
      t = -TERM_CAP;
      clamp_flag = 1'b1;
    end
    return t;
  endfunction

  function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a};
    s = s + {b[63], b};
    if (s[64] != s[63]) begin
      clamp_flag = 1'b1;
      return s[64] ? SUM_MIN : SUM_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] emit_coord(input logic signed [63:0] s,
                                                    inout logic hit);
    logic signed [63:0] q;
    q = rnd_q16(s);
    if (q > 64'sd2147483647) begin
      hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (q < -64'sd2147483648) begin
      hit = 1'b1;
      return 32'sh8000_0000;
    end
    return q[31:0];
  endfunction

  task automatic skin_apply(input skin_item_t it);
    logic signed [63:0] w64;
    vert_out_t          v;
    int                 h;
    h = int'(it.handle);
    if (it.mode == MODE_LOAD) begin
      if (h < MAX_HANDLES && it.element < COEFFS) xform[h][it.element] = it.coeff;
      return;
    end
    if (h < MAX_HANDLES) begin
      w64 = {47'd0, it.weight};
      acc_x = sat_sum(acc_x, row_term(h, 0, it.px, it.py, it.pz) * w64);
      acc_y = sat_sum(acc_y, row_term(h, 1, it.px, it.py, it.pz) * w64);
      acc_z = sat_sum(acc_z, row_term(h, 2, it.px, it.py, it.pz) * w64);
    end
    if (it.last) begin
      v.sat = clamp_flag;
      v.x = emit_coord(acc_x, v.sat);
      v.y = emit_coord(acc_y, v.sat);
      v.z = emit_coord(acc_z, v.sat);
      expected_verts.push_back(v);
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
      clamp_flag = 1'b0;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR %0t %s: got %h, expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic signed [31:0] pick_edge();
    case ($urandom_range(0, 4))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sh0000_0000;
      3: return 32'sh0000_0001;
      default: return 32'shFFFF_FFFF;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coeff();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return pick_edge();
      2: return $urandom_range(0, 1) ? ONE_Q16 : -ONE_Q16;
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic logic signed [31:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return pick_edge();
      default: return int'($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    endcase
  endfunction

  function automatic logic [16:0] rand_weight();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic int pick_loaded();
    int h;
    do begin
      h = $urandom_range(0, MAX_HANDLES - 1);
    end while (gen_loaded[h] != {COEFFS{1'b1}});
    return h;
  endfunction

  task automatic push_load(input int h, input int e, input logic signed [31:0] c);
    skin_item_t it;
    it.mode = MODE_LOAD;
    it.handle = 4'(h);
    it.element = 4'(e);
    it.coeff = c;
    it.px = $urandom;
    it.py = $urandom;
    it.pz = $urandom;
    it.weight = 17'($urandom);
    it.last = 1'($urandom_range(0, 1));
    it.sync = sync_next;
    sync_next = 1'b0;
    pending_items.push_back(it);
    // loads past the last coefficient are dropped by the block
    if (e < COEFFS) begin
      gen_loaded[h][e] = 1'b1;
      gen_count++;
    end
  endtask

  task automatic push_term(input int h, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z,
                           input logic [16:0] w, input logic last);
    skin_item_t it;
    it.mode = MODE_VERTEX;
    it.handle = 4'(h);
    it.element = 4'($urandom);
    it.coeff = $urandom;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.weight = w;
    it.last = last;
    it.sync = sync_next;
    sync_next = 1'b0;
    pending_items.push_back(it);
    gen_count++;
  endtask

  task automatic reload_handle(input int h);
    for (int e = 0; e < COEFFS; e++) push_load(h, e, rand_coeff());
  endtask

  // driver
  skin_item_t cur_item;
  int         gap_left = 0;
  int         tx_burst = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        skin_apply(cur_item);
        accepted_items <= accepted_items + 1;
      end
      if (tx_burst != 0) begin
        tx_burst--;
      end else if ($urandom_range(0, 39) == 0) begin
        tx_burst = $urandom_range(20, 60);
      end
      if (in_valid && in_stall) begin
        // payload held until the transfer
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0 &&
                   !(pending_items[0].sync && expected_verts.size() != 0)) begin
        cur_item = pending_items.pop_front();
        in_mode      <= cur_item.mode;
        in_handle    <= cur_item.handle;
        in_element   <= cur_item.element;
        in_coeff     <= cur_item.coeff;
        in_pos_x     <= cur_item.px;
        in_pos_y     <= cur_item.py;
        in_pos_z     <= cur_item.pz;
        in_weight    <= cur_item.weight;
        in_last_term <= cur_item.last;
        in_valid     <= 1'b1;
        gap_left = (tx_burst != 0 || hold_left != 0) ? 0 : $urandom_range(0, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done < 2 && accepted_items >= 400 + 600 * holds_done) begin
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // monitor
  int        stall_left = 0;
  int        rx_burst = 0;
  vert_out_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_burst != 0) begin
        rx_burst--;
      end else if ($urandom_range(0, 49) == 0) begin
        rx_burst = $urandom_range(40, 120);
      end
      if (out_valid && !out_stall) begin
        if (expected_verts.size() == 0) begin
          report("result with no vertex pending, x", out_x, '0);
        end else begin
          want = expected_verts.pop_front();
          if (out_x !== want.x) report("out_x", out_x, want.x);
          if (out_y !== want.y) report("out_y", out_y, want.y);
          if (out_z !== want.z) report("out_z", out_z, want.z);
          if (out_saturated !== want.sat)
            report("out_saturated", 32'(out_saturated), 32'(want.sat));
        end
        stall_left = (rx_burst != 0) ? 0 : $urandom_range(0, 16);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0) || (hold_left != 0);
    end
  end

  int cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("linear_blend_skinning: mismatch");
      $finish;
    end
  end

  initial begin
    int                 nterm;
    logic signed [31:0] c;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = MODE_LOAD;
    in_handle = '0;
    in_element = '0;
    in_coeff = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_weight = '0;
    in_last_term = 1'b0;
    out_stall = 1'b0;
    for (int h = 0; h < MAX_HANDLES; h++) gen_loaded[h] = '0;
    sync_next = 1'b0;
    gen_count = 0;

    // handle 0: identity with translation, z offset at the top of the range
    for (int e = 0; e < COEFFS; e++) begin
      case (e)
        0, 5, 10: c = ONE_Q16;
        3:        c = 32'sh0002_8000;
        7:        c = -32'sh0001_4000;
        11:       c = 32'sh7FFF_FFFF;
        default:  c = '0;
      endcase
      push_load(0, e, c);
    end
    // out-of-range elements are dropped, last_term on a load is ignored
    push_load(0, 13, 32'sh1234_5678);
    pending_items[$].last = 1'b1;
    push_load(3, 15, 32'shFFFF_FFFF);
    // joint moves on one handle with weights from zero up to just under two
    push_term(0, ONE_Q16, 2 * ONE_Q16, 3 * ONE_Q16, 17'd65536, 1'b1);
    push_term(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd0, 1'b0);
    push_term(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 17'd131071, 1'b1);
    push_term(0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 17'd65536, 1'b1);
    // handle 15: extreme coefficients drive term clamp and sum overflow
    for (int e = 0; e < COEFFS; e++)
      push_load(15, e, e[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
    push_term(15, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 17'd131071, 1'b0);
    push_term(15, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 17'd131071, 1'b1);
    push_term(0, ONE_Q16, ONE_Q16, ONE_Q16, 17'd32768, 1'b0);
    push_term(15, 32'sh0000_0100, -32'sh0000_0100, 32'sh0000_0001, 17'd32768, 1'b1);

    gen_count = 0;
    sync_next = 1'b1;
    while (gen_count < N_RANDOM) begin
      if ($urandom_range(0, 49) == 0) sync_next = 1'b1;
      case ($urandom_range(0, 9))
        0: reload_handle($urandom_range(0, MAX_HANDLES - 1));
        1, 2: push_load($urandom_range(0, MAX_HANDLES - 1), $urandom_range(0, 15),
                        rand_coeff());
        default: begin
          nterm = $urandom_range(1, 4);
          for (int t = 0; t < nterm; t++) begin
            // a load slipped in between terms of one vertex
            if ($urandom_range(0, 11) == 0)
              push_load($urandom_range(0, MAX_HANDLES - 1), $urandom_range(0, 15),
                        rand_coeff());
            if (nterm == 1 && $urandom_range(0, 9) == 0)
              push_term(pick_loaded(), rand_pos(), rand_pos(), rand_pos(), 17'd65536, 1'b1);
            else
              push_term(pick_loaded(), rand_pos(), rand_pos(), rand_pos(), rand_weight(),
                        t == nterm - 1);
          end
        end
      endcase
    end
    total_items = pending_items.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (expected_verts.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("linear_blend_skinning: match");
    end else begin
      $display("linear_blend_skinning: mismatch");
    end
    $finish;
  end

endmodule
